### rtl/ean13_digit_run_decoder_core_defines.svh
// Assertion macros for the digit run decoder.
`ifndef EAN13_DIGIT_RUN_DECODER_CORE_DEFINES_SVH
`define EAN13_DIGIT_RUN_DECODER_CORE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define E13DR_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Same-cycle implication
`define E13DR_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define E13DR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/e13dr_pkg.sv
// Shared constants, types and the threshold function of the digit run decoder.
package e13dr_pkg;

    localparam int WIDTH_W           = 8;
    localparam int LEN_W             = 11;
    localparam int CODE_W            = 5;
    localparam int MOD_W             = 3;
    localparam int MODULES_PER_DIGIT = 7;
    localparam int RUNS_PER_DIGIT    = 4;
    localparam int IDX_W             = 2;
    localparam int MAX_MODS          = 4;
    localparam int PATTERN_COUNT     = 20;
    localparam int RIGHT_COUNT       = 10;

    localparam logic [LEN_W-1:0] COUNT_MAX = {LEN_W{1'b1}};
    localparam logic [MOD_W-1:0] MOD_NONE  = '0;

    typedef logic [LEN_W-1:0] len_t;
    typedef logic [MOD_W-1:0] mod_t;

    // Module counts per pattern, first run first; codes 10-19 are the even-parity set
    localparam mod_t PATTERNS [PATTERN_COUNT][RUNS_PER_DIGIT] = '{
        '{3'd3, 3'd2, 3'd1, 3'd1}, '{3'd2, 3'd2, 3'd2, 3'd1}, '{3'd2, 3'd1, 3'd2, 3'd2},
        '{3'd1, 3'd4, 3'd1, 3'd1}, '{3'd1, 3'd1, 3'd3, 3'd2}, '{3'd1, 3'd2, 3'd3, 3'd1},
        '{3'd1, 3'd1, 3'd1, 3'd4}, '{3'd1, 3'd3, 3'd1, 3'd2}, '{3'd1, 3'd2, 3'd1, 3'd3},
        '{3'd3, 3'd1, 3'd1, 3'd2}, '{3'd1, 3'd1, 3'd2, 3'd3}, '{3'd1, 3'd2, 3'd2, 3'd2},
        '{3'd2, 3'd2, 3'd1, 3'd2}, '{3'd1, 3'd1, 3'd4, 3'd1}, '{3'd2, 3'd3, 3'd1, 3'd1},
        '{3'd1, 3'd3, 3'd2, 3'd1}, '{3'd4, 3'd1, 3'd1, 3'd1}, '{3'd2, 3'd1, 3'd3, 3'd1},
        '{3'd3, 3'd1, 3'd2, 3'd1}, '{3'd2, 3'd1, 3'd1, 3'd3}
    };

    // Rounding thresholds: a run rounds to k modules when thr[k-1] < len <= thr[k]
    typedef struct packed {
        len_t [MAX_MODS:0] thr;
        len_t              limit;
    } thr_t;

    // Snapshot handed to the matcher
    typedef struct packed {
        logic                        emit;
        logic                        open;
        logic                        half;
        len_t [RUNS_PER_DIGIT-1:0]   len;
    } dec_t;

    // Thresholds and window length for a module width (zero acts as one)
    function automatic thr_t thr_of(input logic [WIDTH_W-1:0] w_raw);
        logic [WIDTH_W-1:0] w;
        thr_t               t;
        w = (w_raw == '0) ? WIDTH_W'(1) : w_raw;
        for (int k = 0; k <= MAX_MODS; k++) begin
            t.thr[k] = LEN_W'(k) * LEN_W'(w) + LEN_W'(w[WIDTH_W-1:1]);
        end
        t.limit = LEN_W'(MODULES_PER_DIGIT) * LEN_W'(w);
        return t;
    endfunction

endpackage

### rtl/e13dr_cfg.sv
// Module width register with precomputed rounding thresholds.
module e13dr_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [e13dr_pkg::WIDTH_W-1:0] cfg_module_width,
    output e13dr_pkg::thr_t               thr
);

    e13dr_pkg::thr_t thr_reg;

    assign cfg_ready = 1'b1;
    assign thr       = thr_reg;

    // Thresholds are derived at the write beat so they are ready at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= e13dr_pkg::thr_of(e13dr_pkg::WIDTH_W'(1));
        end else if (cfg_valid) begin
            thr_reg <= e13dr_pkg::thr_of(cfg_module_width);
        end
    end

endmodule

### rtl/e13dr_runs.sv
// Run tracker: run lengths, window count and the point at which a digit is decoded.
module e13dr_runs (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic            pixel_black,
    input  logic            digit_start,
    input  logic            left_half,
    input  e13dr_pkg::len_t limit,
    output e13dr_pkg::dec_t dec
);

    localparam int RUNS = e13dr_pkg::RUNS_PER_DIGIT;

    e13dr_pkg::len_t [RUNS-1:0]    len_reg, len_next, len_upd;
    logic [e13dr_pkg::IDX_W-1:0]   idx_reg, idx_next, idx_upd;
    logic                          color_reg, color_next;
    e13dr_pkg::len_t               wc_reg, wc_next, wc_upd;
    logic                          open_reg, open_next;
    logic                          half_reg, half_next;
    logic                          new_run, run_over, win_end, emit;

    // Continue the current run or start the next one
    always_comb begin
        new_run  = (pixel_black != color_reg);
        run_over = new_run && (idx_reg == e13dr_pkg::IDX_W'(RUNS - 1));
        idx_upd  = new_run ? idx_reg + 1'b1 : idx_reg;
        for (int z = 0; z < RUNS; z++) begin
            len_upd[z] = len_reg[z];
            if (!new_run && (e13dr_pkg::IDX_W'(z) == idx_reg)
                    && (len_reg[z] != e13dr_pkg::COUNT_MAX)) begin
                len_upd[z] = len_reg[z] + 1'b1;
            end else if (new_run && !run_over && (e13dr_pkg::IDX_W'(z) == idx_upd)) begin
                len_upd[z] = e13dr_pkg::LEN_W'(1);
            end
        end
        wc_upd  = (wc_reg == e13dr_pkg::COUNT_MAX) ? wc_reg : wc_reg + 1'b1;
        win_end = (wc_upd >= limit);
    end

    // Window control
    always_comb begin
        len_next   = len_reg;
        idx_next   = idx_reg;
        color_next = color_reg;
        wc_next    = wc_reg;
        open_next  = open_reg;
        half_next  = half_reg;
        emit       = 1'b0;
        if (step) begin
            if (digit_start) begin
                emit       = open_reg;
                len_next   = '0;
                len_next[0] = e13dr_pkg::LEN_W'(1);
                idx_next   = '0;
                color_next = pixel_black;
                wc_next    = e13dr_pkg::LEN_W'(1);
                open_next  = 1'b1;
                half_next  = left_half;
            end else if (open_reg) begin
                if (run_over) begin
                    emit      = 1'b1;
                    open_next = 1'b0;
                end else begin
                    len_next   = len_upd;
                    idx_next   = idx_upd;
                    color_next = pixel_black;
                    wc_next    = wc_upd;
                    if (win_end) begin
                        emit      = 1'b1;
                        open_next = 1'b0;
                    end
                end
            end
        end
    end

    // Window end decodes the lengths including this pixel, other closes the old ones
    assign dec.emit = emit;
    assign dec.open = open_reg;
    assign dec.half = half_reg;
    assign dec.len  = (step && !digit_start && open_reg && !run_over) ? len_upd : len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            idx_reg   <= '0;
            color_reg <= 1'b0;
            wc_reg    <= '0;
            open_reg  <= 1'b0;
            half_reg  <= 1'b0;
        end else begin
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            color_reg <= color_next;
            wc_reg    <= wc_next;
            open_reg  <= open_next;
            half_reg  <= half_next;
        end
    end

endmodule

### rtl/e13dr_match.sv
// Rounds run lengths to module counts and looks them up in the pattern table.
module e13dr_match (
    input  e13dr_pkg::dec_t                dec,
    input  e13dr_pkg::thr_t                thr,
    output logic [e13dr_pkg::CODE_W-1:0]   code,
    output logic                           matched
);

    localparam int RUNS = e13dr_pkg::RUNS_PER_DIGIT;

    e13dr_pkg::mod_t mods [RUNS];

    // Module count per run by threshold window; anything else is no count
    always_comb begin
        for (int z = 0; z < RUNS; z++) begin
            mods[z] = e13dr_pkg::MOD_NONE;
            for (int k = 1; k <= e13dr_pkg::MAX_MODS; k++) begin
                if ((dec.len[z] > thr.thr[k-1]) && (dec.len[z] <= thr.thr[k])) begin
                    mods[z] = e13dr_pkg::MOD_W'(k);
                end
            end
        end
    end

    // First matching entry wins; the even-parity set (codes 10-19) only for a left-half window
    always_comb begin
        logic eq;
        code    = '0;
        matched = 1'b0;
        for (int i = e13dr_pkg::PATTERN_COUNT - 1; i >= 0; i--) begin
            eq = (i < e13dr_pkg::RIGHT_COUNT) || dec.half;
            for (int z = 0; z < RUNS; z++) begin
                eq = eq && (mods[z] == e13dr_pkg::PATTERNS[i][z]);
            end
            if (eq) begin
                code    = e13dr_pkg::CODE_W'(i);
                matched = 1'b1;
            end
        end
    end

endmodule

### rtl/ean13_digit_run_decoder_core.sv
// The closing pixel is taken into the input register; its digit is then registered in the result register.
// Throughput: one pixel per cycle; s_ready drops only while both registers are full, m_ready low.
// The run update, rounding compare and table lookup all sit between those two registers.
// Reset (aresetn low, synchronous): module width 1, no window open, both registers empty.
`include "ean13_digit_run_decoder_core_defines.svh"

module ean13_digit_run_decoder_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [e13dr_pkg::WIDTH_W-1:0] cfg_module_width,
    // pixel input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_pixel_black,
    input  logic                          s_digit_start,
    input  logic                          s_left_half,
    // decoded digits
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [e13dr_pkg::CODE_W-1:0]  m_code,
    output logic                          m_matched
);

    e13dr_pkg::thr_t              thr;
    e13dr_pkg::dec_t              dec;
    logic                         in_vld_reg, in_vld_next;
    logic                         pix_reg, start_reg, half_reg;
    logic                         out_free, fire;
    logic [e13dr_pkg::CODE_W-1:0] code;
    logic                         matched;
    logic                         m_valid_reg, m_valid_next;
    logic [e13dr_pkg::CODE_W-1:0] m_code_reg;
    logic                         m_matched_reg;

    e13dr_cfg u_cfg (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_module_width (cfg_module_width),
        .thr              (thr)
    );

    e13dr_runs u_runs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (fire),
        .pixel_black (pix_reg),
        .digit_start (start_reg),
        .left_half   (half_reg),
        .limit       (thr.limit),
        .dec         (dec)
    );

    e13dr_match u_match (
        .dec     (dec),
        .thr     (thr),
        .code    (code),
        .matched (matched)
    );

    // Beat handshake
    assign out_free    = !m_valid_reg || m_ready;
    assign fire        = in_vld_reg && out_free;
    assign s_ready     = !in_vld_reg || out_free;
    assign in_vld_next = (s_valid && s_ready) ? 1'b1 : (fire ? 1'b0 : in_vld_reg);
    assign m_valid_next = out_free ? (fire && dec.emit) : m_valid_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pix_reg   <= s_pixel_black;
            start_reg <= s_digit_start;
            half_reg  <= s_left_half;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && dec.emit) begin
            m_code_reg    <= code;
            m_matched_reg <= matched;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_code    = m_code_reg;
    assign m_matched = m_matched_reg;

    // Checks
    `E13DR_ASSERT_IMPLY(a_emit_from_open, fire && dec.emit, dec.open, "result from a closed window")
    `E13DR_ASSERT_NEXT(a_in_hold, in_vld_reg && !fire,
        in_vld_reg && $stable(pix_reg) && $stable(start_reg), "pending pixel lost or changed")
    `E13DR_ASSERT_IMPLY(a_code_range, m_valid_reg && m_matched_reg,
        m_code_reg < e13dr_pkg::CODE_W'(e13dr_pkg::PATTERN_COUNT), "code out of range")

endmodule
